FILE: hw/rtl/swm_pkg.sv
// Package of the segmented word memory: field widths, operation and status
// codes, and the command and status structs between controller and datapath.
// Used by the controller, the datapath, the top level and the testbench; depends on nothing.
package swm_pkg;

    // Widths of the item fields.
    localparam int FUNC_W   = 3;
    localparam int ID_W     = 6;
    localparam int OFF_W    = 10;
    localparam int WORD_W   = 32;
    localparam int SIZE_W   = 11;
    localparam int STATUS_W = 3;

    // Default geometry of the memory.
    localparam int SEGMENTS_DEF  = 64;
    localparam int MAX_WORDS_DEF = 1024;

    // Operation codes carried by func.
    localparam logic [FUNC_W-1:0] FN_LOAD  = 3'd0;
    localparam logic [FUNC_W-1:0] FN_STORE = 3'd1;
    localparam logic [FUNC_W-1:0] FN_MAP   = 3'd2;
    localparam logic [FUNC_W-1:0] FN_UNMAP = 3'd3;
    localparam logic [FUNC_W-1:0] FN_COPY  = 3'd4;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_UNMAPPED = 3'd1;
    localparam logic [STATUS_W-1:0] ST_OFFSET   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_SIZE     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOFREE   = 3'd4;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;    // latch the input item and read the segment tables
        logic lookup;    // check the operation and commit its table updates
        logic capture;   // take the loaded word from the word memory
        logic sweep;     // run one step of a zero fill or a segment copy
        logic out_load;  // move the finished result into the output register
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic go_load;     // lookup started a word read
        logic go_sweep;    // lookup started a zero fill or a copy
        logic sweep_done;  // all words of the sweep are written
        logic out_free;    // the output register can take a result
    } sts_t;

endpackage

FILE: hw/rtl/swm_ram.sv
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. Depends on nothing.
module swm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                          clk,
    input  logic                                          we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                              wdata,
    input  logic                                          re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                              rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read port; the data holds until the next read.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: hw/rtl/swm_ctrl.sv
// Controller of the segmented word memory: sequences accept, lookup, word
// read, sweep and result hand-off. Depends on swm_pkg.
module swm_ctrl
    import swm_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_LOOKUP = 5'b00010,
        S_LDWAIT = 5'b00100,
        S_SWEEP  = 5'b01000,
        S_DONE   = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
                if (in_valid)
                begin
                    state_next = S_LOOKUP;
                end
            end
            S_LOOKUP:
            begin
                cmd.lookup = 1'b1;
                if (sts.go_load)
                begin
                    state_next = S_LDWAIT;
                end
                else if (sts.go_sweep)
                begin
                    state_next = S_SWEEP;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_LDWAIT:
            begin
                cmd.capture = 1'b1;
                state_next  = S_DONE;
            end
            S_SWEEP:
            begin
                cmd.sweep = 1'b1;
                if (sts.sweep_done)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                cmd.out_load = sts.out_free;
                if (sts.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: hw/rtl/swm_dp.sv
// Datapath of the segmented word memory: item registers, segment tables,
// free-id stack, word memory, sweep counters and output register.
// Depends on swm_pkg and swm_ram.
module swm_dp
    import swm_pkg::*;
#(
    parameter int SEGMENTS  = SEGMENTS_DEF,
    parameter int MAX_WORDS = MAX_WORDS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  cmd_t                cmd,
    output sts_t                sts,
    input  logic [FUNC_W-1:0]   func,
    input  logic [ID_W-1:0]     seg_id,
    input  logic [OFF_W-1:0]    offset,
    input  logic [WORD_W-1:0]   write_word,
    input  logic [SIZE_W-1:0]   seg_size,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [WORD_W-1:0]   read_word,
    output logic [ID_W-1:0]     new_id,
    output logic [STATUS_W-1:0] status
);

    localparam int IDW   = $clog2(SEGMENTS);
    localparam int CW    = $clog2(SEGMENTS + 1);
    localparam int LW    = $clog2(MAX_WORDS + 1);
    localparam int DEPTH = SEGMENTS * MAX_WORDS;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [AW-1:0] SLOT = AW'(MAX_WORDS);

    // Latched item.
    logic [FUNC_W-1:0] func_reg, func_next;
    logic [ID_W-1:0]   id_reg, id_next;
    logic [OFF_W-1:0]  off_reg, off_next;
    logic [WORD_W-1:0] word_reg, word_next;
    logic [SIZE_W-1:0] size_reg, size_next;

    // Segment state held in flip-flops.
    logic [SEGMENTS-1:0] seg_valid_reg, seg_valid_next;
    logic [CW-1:0]       fc_reg, fc_next;
    logic [CW-1:0]       nf_reg, nf_next;

    // Sweep control.
    logic          sw_copy_reg, sw_copy_next;
    logic [AW-1:0] sw_base_reg, sw_base_next;
    logic [LW-1:0] sw_len_reg, sw_len_next;
    logic [LW-1:0] rd_cnt_reg, rd_cnt_next;
    logic [LW-1:0] wr_cnt_reg, wr_cnt_next;
    logic          wr_pend_reg, wr_pend_next;

    // Result and output registers.
    logic [WORD_W-1:0]   res_read_reg, res_read_next;
    logic [ID_W-1:0]     res_nid_reg, res_nid_next;
    logic [STATUS_W-1:0] res_st_reg, res_st_next;
    logic [WORD_W-1:0]   out_read_reg, out_read_next;
    logic [ID_W-1:0]     out_nid_reg, out_nid_next;
    logic [STATUS_W-1:0] out_st_reg, out_st_next;
    logic                out_valid_reg, out_valid_next;

    // Memory ports.
    logic           len_we, len_re;
    logic [IDW-1:0] len_waddr, len_raddr;
    logic [LW-1:0]  len_wdata, len_rdata;
    logic           free_we, free_re;
    logic [IDW-1:0] free_waddr, free_raddr;
    logic [IDW-1:0] free_wdata, free_rdata;
    logic              word_we, word_re;
    logic [AW-1:0]     word_waddr, word_raddr;
    logic [WORD_W-1:0] word_wdata, word_rdata;

    // Lookup helpers.
    logic [IDW-1:0] id_idx;
    logic           id_live;
    logic [AW-1:0]  id_addr;
    logic [IDW-1:0] got;
    logic [IDW-1:0] got_fix;
    logic           got_ok;

    assign id_idx  = IDW'(id_reg);
    assign id_live = (32'(id_reg) < SEGMENTS) && seg_valid_reg[id_idx];
    assign id_addr = AW'(id_idx) * SLOT + AW'(off_reg);

    swm_ram #(.WIDTH(LW), .DEPTH(SEGMENTS)) u_len_ram (
        .clk   (clk),
        .we    (len_we),
        .waddr (len_waddr),
        .wdata (len_wdata),
        .re    (len_re),
        .raddr (len_raddr),
        .rdata (len_rdata)
    );

    swm_ram #(.WIDTH(IDW), .DEPTH(SEGMENTS)) u_free_ram (
        .clk   (clk),
        .we    (free_we),
        .waddr (free_waddr),
        .wdata (free_wdata),
        .re    (free_re),
        .raddr (free_raddr),
        .rdata (free_rdata)
    );

    swm_ram #(.WIDTH(WORD_W), .DEPTH(DEPTH)) u_word_ram (
        .clk   (clk),
        .we    (word_we),
        .waddr (word_waddr),
        .wdata (word_wdata),
        .re    (word_re),
        .raddr (word_raddr),
        .rdata (word_rdata)
    );

    // Id that a map would take: top of the free stack, else the next fresh id.
    always_comb
    begin
        got_ok = 1'b1;
        if (fc_reg != '0)
        begin
            got = free_rdata;
        end
        else
        begin
            got = IDW'(nf_reg);
            if (32'(nf_reg) >= SEGMENTS)
            begin
                got_ok = 1'b0;
            end
        end
        got_fix = (32'(got) < SEGMENTS) ? got : '0;
    end

    // Register next values and memory controls.
    always_comb
    begin
        func_next      = func_reg;
        id_next        = id_reg;
        off_next       = off_reg;
        word_next      = word_reg;
        size_next      = size_reg;
        seg_valid_next = seg_valid_reg;
        fc_next        = fc_reg;
        nf_next        = nf_reg;
        sw_copy_next   = sw_copy_reg;
        sw_base_next   = sw_base_reg;
        sw_len_next    = sw_len_reg;
        rd_cnt_next    = rd_cnt_reg;
        wr_cnt_next    = wr_cnt_reg;
        wr_pend_next   = wr_pend_reg;
        res_read_next  = res_read_reg;
        res_nid_next   = res_nid_reg;
        res_st_next    = res_st_reg;
        out_read_next  = out_read_reg;
        out_nid_next   = out_nid_reg;
        out_st_next    = out_st_reg;
        out_valid_next = out_valid_reg;

        len_we     = 1'b0;
        len_waddr  = id_idx;
        len_wdata  = sw_len_reg;
        len_re     = 1'b0;
        len_raddr  = IDW'(seg_id);
        free_we    = 1'b0;
        free_waddr = IDW'(fc_reg);
        free_wdata = id_idx;
        free_re    = 1'b0;
        free_raddr = IDW'(fc_reg - 1'b1);
        word_we    = 1'b0;
        word_waddr = id_addr;
        word_wdata = word_reg;
        word_re    = 1'b0;
        word_raddr = id_addr;

        sts.go_load    = 1'b0;
        sts.go_sweep   = 1'b0;
        sts.sweep_done = (rd_cnt_reg == sw_len_reg) && !wr_pend_reg;
        sts.out_free   = !out_valid_reg || out_ready;

        // Take the item and read its segment length and the stack top.
        if (cmd.accept)
        begin
            func_next = func;
            id_next   = seg_id;
            off_next  = offset;
            word_next = write_word;
            size_next = seg_size;
            len_re    = 1'b1;
            free_re   = 1'b1;
        end

        // Check the operation and commit its table updates.
        if (cmd.lookup)
        begin
            res_read_next = '0;
            res_nid_next  = '0;
            res_st_next   = ST_OK;
            rd_cnt_next   = '0;
            wr_cnt_next   = '0;
            wr_pend_next  = 1'b0;
            case (func_reg)
                FN_LOAD, FN_STORE:
                begin
                    if (!id_live)
                    begin
                        res_st_next = ST_UNMAPPED;
                    end
                    else if (32'(off_reg) >= 32'(len_rdata))
                    begin
                        res_st_next = ST_OFFSET;
                    end
                    else if (func_reg == FN_LOAD)
                    begin
                        word_re     = 1'b1;
                        sts.go_load = 1'b1;
                    end
                    else
                    begin
                        word_we = 1'b1;
                    end
                end
                FN_MAP:
                begin
                    if (32'(size_reg) > MAX_WORDS)
                    begin
                        res_st_next = ST_SIZE;
                    end
                    else if (!got_ok)
                    begin
                        res_st_next = ST_NOFREE;
                    end
                    else
                    begin
                        if (fc_reg != '0)
                        begin
                            fc_next = fc_reg - 1'b1;
                        end
                        else
                        begin
                            nf_next = nf_reg + 1'b1;
                        end
                        len_we                  = 1'b1;
                        len_waddr               = got_fix;
                        len_wdata               = LW'(size_reg);
                        seg_valid_next[got_fix] = 1'b1;
                        res_nid_next            = ID_W'(got_fix);
                        sw_copy_next            = 1'b0;
                        sw_base_next            = AW'(got_fix) * SLOT;
                        sw_len_next             = LW'(size_reg);
                        sts.go_sweep            = 1'b1;
                    end
                end
                FN_UNMAP:
                begin
                    if (!id_live || (32'(fc_reg) >= SEGMENTS))
                    begin
                        res_st_next = ST_UNMAPPED;
                    end
                    else
                    begin
                        seg_valid_next[id_idx] = 1'b0;
                        free_we                = 1'b1;
                        fc_next                = fc_reg + 1'b1;
                    end
                end
                FN_COPY:
                begin
                    if (!id_live || !seg_valid_reg[0])
                    begin
                        res_st_next = ST_UNMAPPED;
                    end
                    else if (id_idx != '0)
                    begin
                        len_we       = 1'b1;
                        len_waddr    = '0;
                        len_wdata    = len_rdata;
                        sw_copy_next = 1'b1;
                        sw_base_next = AW'(id_idx) * SLOT;
                        sw_len_next  = len_rdata;
                        sts.go_sweep = 1'b1;
                    end
                end
                default:
                begin
                    res_st_next = ST_OK;
                end
            endcase
        end

        // Take the loaded word.
        if (cmd.capture)
        begin
            res_read_next = word_rdata;
        end

        // One sweep step: zero one word, or read one word and write the last read.
        if (cmd.sweep)
        begin
            wr_pend_next = 1'b0;
            if (rd_cnt_reg != sw_len_reg)
            begin
                rd_cnt_next = rd_cnt_reg + 1'b1;
                if (sw_copy_reg)
                begin
                    word_re      = 1'b1;
                    word_raddr   = sw_base_reg + AW'(rd_cnt_reg);
                    wr_pend_next = 1'b1;
                end
                else
                begin
                    word_we    = 1'b1;
                    word_waddr = sw_base_reg + AW'(rd_cnt_reg);
                    word_wdata = '0;
                end
            end
            if (wr_pend_reg)
            begin
                word_we     = 1'b1;
                word_waddr  = AW'(wr_cnt_reg);
                word_wdata  = word_rdata;
                wr_cnt_next = wr_cnt_reg + 1'b1;
            end
        end

        // Output register: drain the taken item, then load a new result.
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
            out_read_next  = res_read_reg;
            out_nid_next   = res_nid_reg;
            out_st_next    = res_st_reg;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seg_valid_reg <= '0;
            fc_reg        <= '0;
            nf_reg        <= '0;
            rd_cnt_reg    <= '0;
            wr_cnt_reg    <= '0;
            wr_pend_reg   <= 1'b0;
            sw_len_reg    <= '0;
            sw_copy_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            seg_valid_reg <= seg_valid_next;
            fc_reg        <= fc_next;
            nf_reg        <= nf_next;
            rd_cnt_reg    <= rd_cnt_next;
            wr_cnt_reg    <= wr_cnt_next;
            wr_pend_reg   <= wr_pend_next;
            sw_len_reg    <= sw_len_next;
            sw_copy_reg   <= sw_copy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        func_reg     <= func_next;
        id_reg       <= id_next;
        off_reg      <= off_next;
        word_reg     <= word_next;
        size_reg     <= size_next;
        sw_base_reg  <= sw_base_next;
        res_read_reg <= res_read_next;
        res_nid_reg  <= res_nid_next;
        res_st_reg   <= res_st_next;
        out_read_reg <= out_read_next;
        out_nid_reg  <= out_nid_next;
        out_st_reg   <= out_st_next;
    end

    assign out_valid = out_valid_reg;
    assign read_word = out_read_reg;
    assign new_id    = out_nid_reg;
    assign status    = out_st_reg;

endmodule

FILE: hw/rtl/segmented_word_memory.sv
// Top level of the segmented word memory: controller plus datapath.
// Depends on swm_pkg, swm_ctrl, swm_dp and swm_ram.
//
//   channel  handshake              payload
//   input    in_valid / in_ready    func, seg_id, offset, write_word, seg_size
//   output   out_valid / out_ready  read_word, new_id, status
//
// One item at a time. Load reads its word after the lookup; store, unmap, copy
// onto itself, errors and unknown operations finish in the lookup. Map zeroes
// the new segment, one zeroed word per cycle on the single write port of the
// word memory. Copy moves the source segment into segment 0, one word per cycle
// behind a registered read of the word memory.
// Reset clears the segment valid bits and id counters at once; no clearing pass.
// A new item is accepted while a result waits; its result then holds until the
// output register is free.
module segmented_word_memory
    import swm_pkg::*;
#(
    parameter int SEGMENTS  = SEGMENTS_DEF,
    parameter int MAX_WORDS = MAX_WORDS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [FUNC_W-1:0]   func,
    input  logic [ID_W-1:0]     seg_id,
    input  logic [OFF_W-1:0]    offset,
    input  logic [WORD_W-1:0]   write_word,
    input  logic [SIZE_W-1:0]   seg_size,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [WORD_W-1:0]   read_word,
    output logic [ID_W-1:0]     new_id,
    output logic [STATUS_W-1:0] status
);

    cmd_t cmd;
    sts_t sts;

    swm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    swm_dp #(
        .SEGMENTS  (SEGMENTS),
        .MAX_WORDS (MAX_WORDS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .func       (func),
        .seg_id     (seg_id),
        .offset     (offset),
        .write_word (write_word),
        .seg_size   (seg_size),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .read_word  (read_word),
        .new_id     (new_id),
        .status     (status)
    );

endmodule

FILE: verif/segmented_word_memory_tb.sv
// Self-checking testbench for segmented_word_memory: directed and random
// load, store, map, unmap and copy items checked against a scoreboard.
// Depends on swm_pkg and the segmented_word_memory RTL only.
module segmented_word_memory_tb
    import swm_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SEGMENTS     = SEGMENTS_DEF;
    localparam int MAX_WORDS    = MAX_WORDS_DEF;
    localparam int RANDOM_ITEMS = 700;
    localparam int MAX_GAP      = 19;
    localparam int DRAIN_CYCLES = 60;
    localparam int REPORT_LIMIT = 10;
    localparam int CYCLE_LIMIT  = 4_000_000;

    // Operation codes that the block ignores.
    localparam logic [FUNC_W-1:0] FN_UNDEF_FIRST = 3'd5;
    localparam logic [FUNC_W-1:0] FN_UNDEF_LAST  = 3'd7;

    typedef struct packed {
        logic [WORD_W-1:0]   read_word;
        logic [ID_W-1:0]     new_id;
        logic [STATUS_W-1:0] status;
    } result_t;

    // Shadow copy of the segment memory and the queue of results it predicts.
    class swm_scoreboard;
        logic [WORD_W-1:0] word_mem [SEGMENTS*MAX_WORDS];
        logic [SIZE_W-1:0] seg_len [SEGMENTS];
        bit                seg_live [SEGMENTS];
        logic [ID_W-1:0]   free_stack [SEGMENTS];
        int                free_cnt;
        int                fresh_next;
        result_t           pending_results[$];
        int                mismatches;
        int                checked;
        int                func_count [8];
        int                status_count [8];

        function new();
            foreach (seg_len[i])
            begin
                seg_len[i]  = '0;
                seg_live[i] = 1'b0;
            end
            foreach (func_count[i])
            begin
                func_count[i]   = 0;
                status_count[i] = 0;
            end
            free_cnt   = 0;
            fresh_next = 0;
            mismatches = 0;
            checked    = 0;
        endfunction

        // Pick a random mapped id, or -1 when nothing is mapped.
        function int live_id();
            int ids[$];
            foreach (seg_live[i])
            begin
                if (seg_live[i])
                    ids.push_back(i);
            end
            if (ids.size() == 0)
                return -1;
            return ids[$urandom_range(0, ids.size() - 1)];
        endfunction

        // Apply one accepted item to the shadow state and queue its result.
        function void note_item(logic [FUNC_W-1:0] fn, logic [ID_W-1:0] id,
                                logic [OFF_W-1:0] off, logic [WORD_W-1:0] wd,
                                logic [SIZE_W-1:0] sz);
            result_t res;
            int      got;
            int      src;
            res.read_word = '0;
            res.new_id    = '0;
            res.status    = ST_OK;
            got           = -1;
            func_count[fn]++;
            case (fn)
                FN_LOAD, FN_STORE:
                begin
                    if (!seg_live[id])
                        res.status = ST_UNMAPPED;
                    else if (off >= seg_len[id])
                        res.status = ST_OFFSET;
                    else if (fn == FN_LOAD)
                        res.read_word = word_mem[int'(id) * MAX_WORDS + int'(off)];
                    else
                        word_mem[int'(id) * MAX_WORDS + int'(off)] = wd;
                end
                FN_MAP:
                begin
                    // Freed ids are reused last-in first-out before fresh ones.
                    if (sz > MAX_WORDS)
                        res.status = ST_SIZE;
                    else if (free_cnt > 0)
                    begin
                        free_cnt--;
                        got = free_stack[free_cnt];
                    end
                    else if (fresh_next < SEGMENTS)
                    begin
                        got = fresh_next;
                        fresh_next++;
                    end
                    else
                        res.status = ST_NOFREE;
                    if (got >= 0)
                    begin
                        for (int i = 0; i < int'(sz); i++)
                            word_mem[got * MAX_WORDS + i] = '0;
                        seg_len[got]  = sz;
                        seg_live[got] = 1'b1;
                        res.new_id    = ID_W'(got);
                    end
                end
                FN_UNMAP:
                begin
                    if (!seg_live[id] || free_cnt >= SEGMENTS)
                        res.status = ST_UNMAPPED;
                    else
                    begin
                        seg_live[id]         = 1'b0;
                        seg_len[id]          = '0;
                        free_stack[free_cnt] = id;
                        free_cnt++;
                    end
                end
                FN_COPY:
                begin
                    // A copy of segment 0 onto itself leaves everything as it is.
                    if (!seg_live[id] || !seg_live[0])
                        res.status = ST_UNMAPPED;
                    else if (id != 0)
                    begin
                        src = int'(id) * MAX_WORDS;
                        for (int i = 0; i < int'(seg_len[id]); i++)
                            word_mem[i] = word_mem[src + i];
                        seg_len[0] = seg_len[id];
                    end
                end
                default: ;
            endcase
            status_count[res.status]++;
            pending_results.push_back(res);
        endfunction

        // Compare one accepted result with the oldest pending one.
        function void check_result(result_t seen);
            result_t want;
            checked++;
            if (pending_results.size() == 0)
            begin
                if (mismatches < REPORT_LIMIT)
                    $display("Result with no item pending: word %h id %0d status %0d",
                             seen.read_word, seen.new_id, seen.status);
                mismatches++;
                return;
            end
            want = pending_results.pop_front();
            if (seen.read_word !== want.read_word || seen.new_id !== want.new_id ||
                seen.status !== want.status)
            begin
                if (mismatches < REPORT_LIMIT)
                begin
                    $display("Mismatch on result %0d: expected word %h id %0d status %0d",
                             checked, want.read_word, want.new_id, want.status);
                    $display("    got word %h id %0d status %0d",
                             seen.read_word, seen.new_id, seen.status);
                end
                mismatches++;
            end
        endfunction
    endclass

    logic                clk        = 1'b0;
    logic                rst_n      = 1'b0;
    logic                in_valid   = 1'b0;
    logic                in_ready;
    logic [FUNC_W-1:0]   func       = '0;
    logic [ID_W-1:0]     seg_id     = '0;
    logic [OFF_W-1:0]    offset     = '0;
    logic [WORD_W-1:0]   write_word = '0;
    logic [SIZE_W-1:0]   seg_size   = '0;
    logic                out_valid;
    logic                out_ready  = 1'b1;
    logic [WORD_W-1:0]   read_word;
    logic [ID_W-1:0]     new_id;
    logic [STATUS_W-1:0] status;

    swm_scoreboard sb = new();
    int            cycle_count = 0;

    segmented_word_memory dut (
        .clk,
        .rst_n,
        .in_valid,
        .in_ready,
        .func,
        .seg_id,
        .offset,
        .write_word,
        .seg_size,
        .out_valid,
        .out_ready,
        .read_word,
        .new_id,
        .status
    );

    always #10 clk = ~clk;

    // Guard against a hung handshake.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_count, sb.pending_results.size());
            $display("FAIL segmented_word_memory");
            $finish;
        end
    end

    // Present one item after a random gap and hold it until it is accepted.
    task automatic send_item(logic [FUNC_W-1:0] fn, logic [ID_W-1:0] id,
                             logic [OFF_W-1:0] off, logic [WORD_W-1:0] wd,
                             logic [SIZE_W-1:0] sz, bit no_gap);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        func       <= fn;
        seg_id     <= id;
        offset     <= off;
        write_word <= wd;
        seg_size   <= sz;
        do @(posedge clk); while (in_ready !== 1'b1);
        sb.note_item(fn, id, off, wd, sz);
    endtask

    // Result side: random stalls on out_ready, with stretches of none.
    initial
    begin
        int stall;
        int n;
        bit calm_out;
        n        = 0;
        calm_out = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (n % 43 == 0)
                calm_out = ($urandom_range(0, 3) == 0);
            stall = calm_out ? 0 : $urandom_range(0, MAX_GAP);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
                out_ready <= 1'b1;
            end
            do @(posedge clk); while (out_valid !== 1'b1);
            sb.check_result({read_word, new_id, status});
            n++;
        end
    end

    // Item side: reset, directed items, random items, then drain.
    initial
    begin
        int                counted;
        int                k;
        int                phase;
        int                pick;
        int                s;
        int                live;
        int                w_load, w_store, w_map, w_unmap, w_copy;
        bit                wellformed;
        bit                calm_in;
        logic [FUNC_W-1:0] fn;
        logic [ID_W-1:0]   id;
        logic [OFF_W-1:0]  off;
        logic [WORD_W-1:0] wd;
        logic [SIZE_W-1:0] sz;

        calm_in = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Errors on an empty memory, including a copy with segment 0 unmapped.
        send_item(FN_LOAD, 6'd0, 10'd0, 32'd0, 11'd0, calm_in);
        send_item(FN_STORE, '1, '1, '1, '1, calm_in);
        send_item(FN_UNMAP, 6'd5, 10'd0, 32'd0, 11'd0, calm_in);
        send_item(FN_COPY, 6'd0, 10'd0, 32'd0, 11'd0, calm_in);
        // Oversize maps, then the largest map, a map of length zero and a short one.
        send_item(FN_MAP, 6'd0, 10'd0, 32'd0, '1, calm_in);
        send_item(FN_MAP, 6'd0, 10'd0, 32'd0, SIZE_W'(MAX_WORDS + 1), calm_in);
        send_item(FN_MAP, 6'd0, 10'd0, 32'd0, SIZE_W'(MAX_WORDS), calm_in);
        send_item(FN_MAP, 6'd0, 10'd0, 32'd0, 11'd0, calm_in);
        send_item(FN_MAP, 6'd0, 10'd0, 32'd0, 11'd3, calm_in);
        // Word extremes at the ends of segment 0, and offsets past the end.
        send_item(FN_STORE, 6'd0, '1, '1, 11'd0, calm_in);
        send_item(FN_STORE, 6'd0, 10'd0, 32'd0, '1, calm_in);
        send_item(FN_LOAD, 6'd0, '1, 32'd0, 11'd0, calm_in);
        send_item(FN_LOAD, 6'd1, 10'd0, 32'd0, 11'd0, calm_in);
        send_item(FN_STORE, 6'd2, 10'd3, 32'd0, 11'd0, calm_in);
        send_item(FN_STORE, 6'd2, 10'd2, 32'hA5C3_0F96, 11'd0, calm_in);
        // Copy shrinks segment 0 to the source length; then a copy onto itself.
        send_item(FN_COPY, 6'd2, 10'd0, 32'd0, 11'd0, calm_in);
        send_item(FN_LOAD, 6'd0, '1, 32'd0, 11'd0, calm_in);
        send_item(FN_LOAD, 6'd0, 10'd2, 32'd0, 11'd0, calm_in);
        send_item(FN_COPY, 6'd0, 10'd0, 32'd0, 11'd0, calm_in);
        // Unmap segment 0, copy into it, and check last-in first-out reuse.
        send_item(FN_UNMAP, 6'd0, 10'd0, 32'd0, 11'd0, calm_in);
        send_item(FN_COPY, 6'd2, 10'd0, 32'd0, 11'd0, calm_in);
        send_item(FN_UNMAP, 6'd1, 10'd0, 32'd0, 11'd0, calm_in);
        send_item(FN_MAP, 6'd0, 10'd0, 32'd0, 11'd5, calm_in);
        send_item(FN_MAP, 6'd0, 10'd0, 32'd0, 11'd2, calm_in);
        for (int u = FN_UNDEF_FIRST; u <= FN_UNDEF_LAST; u++)
            send_item(FUNC_W'(u), '1, '1, '1, '1, calm_in);

        // Random part: phases that fill the id space, mix, and drain it again.
        counted = 0;
        k       = 0;
        while (counted < RANDOM_ITEMS)
        begin
            if (k % 37 == 0)
                calm_in = ($urandom_range(0, 3) == 0);
            phase = (counted / 40) % 6;
            if (phase < 3)
            begin
                w_load = 10; w_store = 10; w_map = 70; w_unmap = 5; w_copy = 2;
            end
            else if (phase == 3)
            begin
                w_load = 30; w_store = 28; w_map = 12; w_unmap = 10; w_copy = 10;
            end
            else
            begin
                w_load = 17; w_store = 18; w_map = 3; w_unmap = 45; w_copy = 10;
            end

            pick = $urandom_range(0, 99);
            if (pick < w_load)
                fn = FN_LOAD;
            else if (pick < w_load + w_store)
                fn = FN_STORE;
            else if (pick < w_load + w_store + w_map)
                fn = FN_MAP;
            else if (pick < w_load + w_store + w_map + w_unmap)
                fn = FN_UNMAP;
            else if (pick < w_load + w_store + w_map + w_unmap + w_copy)
                fn = FN_COPY;
            else
                fn = FUNC_W'($urandom_range(FN_UNDEF_FIRST, FN_UNDEF_LAST));

            id         = ID_W'($urandom_range(0, SEGMENTS - 1));
            off        = OFF_W'($urandom_range(0, (1 << OFF_W) - 1));
            wd         = $urandom;
            sz         = SIZE_W'($urandom_range(0, 16));
            live       = sb.live_id();
            wellformed = ($urandom_range(0, 99) < 85);

            case (fn)
                FN_LOAD, FN_STORE:
                begin
                    if (wellformed && live >= 0)
                    begin
                        id = ID_W'(live);
                        if (sb.seg_len[live] > 0)
                            off = OFF_W'($urandom_range(0, int'(sb.seg_len[live]) - 1));
                    end
                end
                FN_MAP:
                begin
                    // Mostly short segments; large ones are rare since they fill slowly.
                    s = $urandom_range(0, 99);
                    if (s < 80)
                        sz = SIZE_W'($urandom_range(0, 16));
                    else if (s < 92)
                        sz = SIZE_W'($urandom_range(17, 128));
                    else if (s < 96)
                        sz = SIZE_W'($urandom_range(129, MAX_WORDS));
                    else if (s < 97)
                        sz = SIZE_W'(MAX_WORDS);
                    else
                        sz = SIZE_W'($urandom_range(MAX_WORDS + 1, (1 << SIZE_W) - 1));
                end
                FN_UNMAP, FN_COPY:
                begin
                    if (wellformed && live >= 0)
                        id = ID_W'(live);
                end
                default: ;
            endcase

            send_item(fn, id, off, wd, sz, calm_in);
            if (fn <= FN_COPY)
                counted++;
            k++;
        end

        // Let every result arrive, then watch for stray ones.
        in_valid <= 1'b0;
        while (sb.pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Items: %0d load, %0d store, %0d map, %0d unmap, %0d copy, %0d ignored",
                 sb.func_count[FN_LOAD], sb.func_count[FN_STORE], sb.func_count[FN_MAP],
                 sb.func_count[FN_UNMAP], sb.func_count[FN_COPY],
                 sb.func_count[5] + sb.func_count[6] + sb.func_count[7]);
        $display("Results: %0d checked, %0d ok, %0d unmapped, %0d offset, %0d size, %0d no id",
                 sb.checked, sb.status_count[ST_OK], sb.status_count[ST_UNMAPPED],
                 sb.status_count[ST_OFFSET], sb.status_count[ST_SIZE],
                 sb.status_count[ST_NOFREE]);
        if (sb.mismatches == 0)
            $display("PASS segmented_word_memory");
        else
            $display("FAIL segmented_word_memory");
        $finish;
    end

endmodule

FILE: sim.f
hw/rtl/swm_pkg.sv
hw/rtl/swm_ram.sv
hw/rtl/swm_ctrl.sv
hw/rtl/swm_dp.sv
hw/rtl/segmented_word_memory.sv
verif/segmented_word_memory_tb.sv
